### design/bertlv_pkg.sv
// Shared types and constants for the BER-TLV stream decoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package bertlv_pkg;

    localparam int TAG_W      = 32;
    localparam int LEN_W      = 24;
    localparam int CFG_W      = 24;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [4:0] TAG_MULTI_MARK = 5'h1F;

    typedef enum logic [0:0] {
        CFG_REGION_LENGTH    = 1'b0,
        CFG_REGION_UNBOUNDED = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROLE_TAG     = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_IGNORED = 2'd3
    } role_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TAG_LONG    = 3'd1,
        ST_LEN_LONG    = 3'd2,
        ST_INDEFINITE  = 3'd3,
        ST_OVERRUN     = 3'd4,
        ST_AFTER_END   = 3'd5
    } status_t;

    typedef enum logic [6:0] {
        PH_TAG_FIRST = 7'b0000001,
        PH_TAG_MORE  = 7'b0000010,
        PH_LEN_FIRST = 7'b0000100,
        PH_LEN_MORE  = 7'b0001000,
        PH_VALUE     = 7'b0010000,
        PH_ENDED     = 7'b0100000,
        PH_ERROR     = 7'b1000000
    } phase_t;

    typedef struct packed {
        role_t              role;
        logic [7:0]         data;
        logic               header_done;
        logic [TAG_W-1:0]   tag;
        logic [LEN_W-1:0]   len;
        logic               last_value;
        logic               region_end;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

### design/ber_tlv_stream_decoder_unit.sv
// Top level of the BER-TLV stream decoder: front, result queue and back end.
// Depends on bertlv_pkg, bertlv_front, bertlv_queue and bertlv_back.
`default_nettype none

// The decoder takes one stream byte per cycle while in_stall is low and gives
// one result item per byte: its role (tag, length or value or ignored), the
// byte itself, the tag and length so far, and flags for a finished header, the
// last value byte and the end of the region. The sustained rate is one byte per
// clock while neither side stalls, set by the per-byte state update in the front
// end. A result passes through the queue entry and then the output register
// before it is presented at the outputs. A two-entry queue and an output
// register let input and output stall independently. The user must write
// configuration only while idle; the block itself does not enforce it.
// region_length takes effect at the next byte with restart set.
module ber_tlv_stream_decoder_unit
    import bertlv_pkg::*;
#(
    parameter int MAX_TAG_BYTES    = 4,
    parameter int MAX_LENGTH_BYTES = 3
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        data_byte,
    input  wire logic              restart,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             byte_role,
    output logic [7:0]             passed_byte,
    output logic                   header_done,
    output logic [TAG_W-1:0]       tag_value,
    output logic [LEN_W-1:0]       length_value,
    output logic                   last_value_byte,
    output logic                   region_end,
    output logic [2:0]             status,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic    q_full, q_not_empty, q_pop, push;
    result_t push_item, q_head, out_item;

    assign in_stall = q_full;

    bertlv_front #(
        .MAX_TAG_BYTES    (MAX_TAG_BYTES),
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .restart   (restart),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    bertlv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bertlv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_item    (out_item)
    );

    assign byte_role       = out_item.role;
    assign passed_byte     = out_item.data;
    assign header_done     = out_item.header_done;
    assign tag_value       = out_item.tag;
    assign length_value    = out_item.len;
    assign last_value_byte = out_item.last_value;
    assign region_end      = out_item.region_end;
    assign status          = out_item.status;

endmodule

`default_nettype wire

### design/bertlv_front.sv
// Front end: accepts stream bytes, classifies them and tracks the TLV state.
// Depends on bertlv_pkg; pushes one result per byte into bertlv_queue.
`default_nettype none

module bertlv_front
    import bertlv_pkg::*;
#(
    parameter int MAX_TAG_BYTES    = 4,
    parameter int MAX_LENGTH_BYTES = 3
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [7:0]        data_byte,
    input  wire logic              restart,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              q_full,
    output logic                   push,
    output result_t                push_item
);

    logic [LEN_W-1:0] region_length_reg;
    logic             region_unbounded_reg;

    phase_t           phase_reg, phase_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [2:0]       tag_cnt_reg, tag_cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       len_left_reg, len_left_next;
    logic [LEN_W-1:0] val_left_reg, val_left_next;
    logic [LEN_W-1:0] rgn_left_reg, rgn_left_next;
    status_t          held_reg, held_next;

    phase_t           ph;
    logic [TAG_W-1:0] tag_cur;
    logic [2:0]       tag_cnt_cur;
    logic [LEN_W-1:0] len_cur;
    logic [1:0]       len_left_cur;
    logic [LEN_W-1:0] val_left_cur;
    logic [LEN_W-1:0] rgn_left_cur;
    status_t          held_cur;

    logic             bounded;
    logic             hdr_fire;
    logic [6:0]       len_code;
    result_t          res;

    assign push     = in_valid && !q_full;
    assign bounded  = !region_unbounded_reg;
    assign len_code = data_byte[6:0];

    always_comb
    begin
        ph           = restart ? PH_TAG_FIRST : phase_reg;
        tag_cur      = restart ? '0 : tag_reg;
        tag_cnt_cur  = restart ? '0 : tag_cnt_reg;
        len_cur      = restart ? '0 : len_reg;
        len_left_cur = restart ? '0 : len_left_reg;
        val_left_cur = restart ? '0 : val_left_reg;
        rgn_left_cur = restart ? region_length_reg : rgn_left_reg;
        held_cur     = restart ? ST_OK : held_reg;

        phase_next    = ph;
        tag_next      = tag_cur;
        tag_cnt_next  = tag_cnt_cur;
        len_next      = len_cur;
        len_left_next = len_left_cur;
        val_left_next = val_left_cur;
        rgn_left_next = rgn_left_cur;
        held_next     = held_cur;

        hdr_fire        = 1'b0;
        res.role        = ROLE_IGNORED;
        res.data        = data_byte;
        res.header_done = 1'b0;
        res.last_value  = 1'b0;
        res.region_end  = 1'b0;
        res.status      = ST_OK;

        if (ph == PH_ERROR)
        begin
            res.status = held_cur;
        end
        else if (ph == PH_ENDED)
        begin
            res.status = ST_AFTER_END;
        end
        else if (bounded && rgn_left_cur == '0)
        begin
            if (ph == PH_TAG_FIRST)
            begin
                phase_next = PH_ENDED;
                res.status = ST_AFTER_END;
            end
            else
            begin
                if (ph == PH_VALUE)
                    res.role = ROLE_VALUE;
                else if (ph == PH_TAG_MORE)
                    res.role = ROLE_TAG;
                else
                    res.role = ROLE_LENGTH;
                phase_next = PH_ERROR;
                held_next  = ST_OVERRUN;
                res.status = ST_OVERRUN;
            end
        end
        else
        begin
            if (bounded)
                rgn_left_next = rgn_left_cur - 1'b1;
            case (ph)
                PH_TAG_FIRST:
                begin
                    res.role     = ROLE_TAG;
                    tag_next     = {{(TAG_W-8){1'b0}}, data_byte};
                    tag_cnt_next = 3'd1;
                    len_next     = '0;
                    phase_next   = (data_byte[4:0] == TAG_MULTI_MARK) ? PH_TAG_MORE
                                                                      : PH_LEN_FIRST;
                end
                PH_TAG_MORE:
                begin
                    res.role = ROLE_TAG;
                    if (tag_cnt_cur >= 3'(MAX_TAG_BYTES))
                    begin
                        phase_next = PH_ERROR;
                        held_next  = ST_TAG_LONG;
                        res.status = ST_TAG_LONG;
                    end
                    else
                    begin
                        tag_next     = {tag_cur[TAG_W-9:0], data_byte};
                        tag_cnt_next = tag_cnt_cur + 1'b1;
                        if (!data_byte[7])
                            phase_next = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    res.role = ROLE_LENGTH;
                    if (data_byte[7])
                    begin
                        if (len_code == '0)
                        begin
                            phase_next = PH_ERROR;
                            held_next  = ST_INDEFINITE;
                            res.status = ST_INDEFINITE;
                        end
                        else if (len_code > 7'(MAX_LENGTH_BYTES))
                        begin
                            phase_next = PH_ERROR;
                            held_next  = ST_LEN_LONG;
                            res.status = ST_LEN_LONG;
                        end
                        else
                        begin
                            len_left_next = len_code[1:0];
                            len_next      = '0;
                            phase_next    = PH_LEN_MORE;
                        end
                    end
                    else
                    begin
                        len_next = {{(LEN_W-8){1'b0}}, data_byte};
                        hdr_fire = 1'b1;
                    end
                end
                PH_LEN_MORE:
                begin
                    res.role      = ROLE_LENGTH;
                    len_next      = {len_cur[LEN_W-9:0], data_byte};
                    len_left_next = len_left_cur - 1'b1;
                    hdr_fire      = (len_left_next == 2'd0);
                end
                PH_VALUE:
                begin
                    res.role      = ROLE_VALUE;
                    val_left_next = val_left_cur - 1'b1;
                    if (val_left_next == '0)
                    begin
                        res.last_value = 1'b1;
                        if (bounded && rgn_left_next == '0)
                        begin
                            res.region_end = 1'b1;
                            phase_next     = PH_ENDED;
                        end
                        else
                        begin
                            phase_next = PH_TAG_FIRST;
                        end
                    end
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase

            if (hdr_fire)
            begin
                if (!bounded && tag_next == '0)
                begin
                    res.region_end = 1'b1;
                    phase_next     = PH_ENDED;
                end
                else if (bounded && len_next > rgn_left_next)
                begin
                    phase_next = PH_ERROR;
                    held_next  = ST_OVERRUN;
                    res.status = ST_OVERRUN;
                end
                else
                begin
                    res.header_done = 1'b1;
                    val_left_next   = len_next;
                    if (len_next == '0)
                    begin
                        res.last_value = 1'b1;
                        if (bounded && rgn_left_next == '0)
                        begin
                            res.region_end = 1'b1;
                            phase_next     = PH_ENDED;
                        end
                        else
                        begin
                            phase_next = PH_TAG_FIRST;
                        end
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
        end

        res.tag = tag_next;
        res.len = len_next;
    end

    assign push_item = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_length_reg    <= '0;
            region_unbounded_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REGION_LENGTH:    region_length_reg    <= cfg_data[LEN_W-1:0];
                CFG_REGION_UNBOUNDED: region_unbounded_reg <= cfg_data[0];
                default:              region_length_reg    <= region_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG_FIRST;
            tag_reg      <= '0;
            tag_cnt_reg  <= '0;
            len_reg      <= '0;
            len_left_reg <= '0;
            val_left_reg <= '0;
            rgn_left_reg <= '0;
            held_reg     <= ST_OK;
        end
        else if (push)
        begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            tag_cnt_reg  <= tag_cnt_next;
            len_reg      <= len_next;
            len_left_reg <= len_left_next;
            val_left_reg <= val_left_next;
            rgn_left_reg <= rgn_left_next;
            held_reg     <= held_next;
        end
    end

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR) |-> (held_reg != ST_OK))
        else $error("error phase without a held error code");

    a_header_on_length: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.header_done) |-> (push_item.role == ROLE_LENGTH
                                             && push_item.status == ST_OK))
        else $error("header completed on a byte that is not a clean length byte");

    a_error_held: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !restart && phase_reg == PH_ERROR) |=> (phase_reg == PH_ERROR
                                                          && $stable(held_reg)))
        else $error("held error changed without restart");

endmodule

`default_nettype wire

### design/bertlv_queue.sv
// Short result queue between the decoding front and the output back end.
// Depends on bertlv_pkg for the result type and queue depth.
`default_nettype none

module bertlv_queue
    import bertlv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire result_t  push_item,
    input  wire logic     pop,
    output logic          full,
    output logic          not_empty,
    output result_t       head
);

    result_t              entry [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### design/bertlv_back.sv
// Back end: takes decoded items from the queue into the output register.
// Depends on bertlv_pkg for the result type.
`default_nettype none

module bertlv_back
    import bertlv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_not_empty,
    input  wire result_t  q_head,
    output logic          q_pop,
    input  wire logic     out_stall,
    output logic          out_valid,
    output result_t       out_item
);

    logic    valid_reg;
    result_t item_reg;

    assign q_pop     = q_not_empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for ber_tlv_stream_decoder_unit: it drives a byte stream of BER-TLV
// regions and checks every result item against a behavioral decoder kept in the testbench.
// Depends on bertlv_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_top;
    import bertlv_pkg::*;

    localparam int MAX_TAG = 4;
    localparam int MAX_LEN = 3;
    localparam logic [7:0] LONG_FORM = 8'h80;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 250000;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } stream_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] data_byte = '0;
    logic restart = 1'b0;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    cfg_index_t cfg_index = CFG_REGION_LENGTH;
    logic [CFG_W-1:0] cfg_data = '0;

    logic in_stall;
    logic out_valid;
    logic [1:0] byte_role;
    logic [7:0] passed_byte;
    logic header_done;
    logic [TAG_W-1:0] tag_value;
    logic [LEN_W-1:0] length_value;
    logic last_value_byte;
    logic region_end;
    logic [2:0] status;

    stream_item_t pending_bytes[$];
    result_t byte_reports_due[$];
    stream_item_t next_item;
    result_t want;
    int send_wait = 0;
    bit send_idle_mode = 1'b0;
    int recv_wait = 0;
    bit recv_idle_mode = 1'b1;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    logic [23:0] region_len_cfg = '0;
    logic unbounded_cfg = 1'b1;
    phase_t dec_phase = PH_TAG_FIRST;
    logic [31:0] tag_acc = '0;
    int tag_count = 0;
    logic [23:0] len_acc = '0;
    logic [1:0] len_count = '0;
    logic [23:0] value_count = '0;
    logic [24:0] region_count = '0;
    status_t held_code = ST_OK;

    ber_tlv_stream_decoder_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .restart(restart),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .byte_role(byte_role),
        .passed_byte(passed_byte),
        .header_done(header_done),
        .tag_value(tag_value),
        .length_value(length_value),
        .last_value_byte(last_value_byte),
        .region_end(region_end),
        .status(status),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic status_t enter_error(status_t code);
        dec_phase = PH_ERROR;
        held_code = code;
        return code;
    endfunction

    function automatic result_t decode_byte(logic [7:0] b, logic rs);
        result_t r;
        logic bnd;
        logic hdr_end;
        logic obj_end;
        logic [6:0] c;
        if (rs)
        begin
            dec_phase = PH_TAG_FIRST;
            tag_acc = '0;
            tag_count = 0;
            len_acc = '0;
            len_count = '0;
            value_count = '0;
            held_code = ST_OK;
            region_count = {1'b0, region_len_cfg};
        end
        r = '0;
        r.role = ROLE_IGNORED;
        r.status = ST_OK;
        r.data = b;
        bnd = !unbounded_cfg;
        hdr_end = 1'b0;
        obj_end = 1'b0;
        if (dec_phase == PH_ERROR)
        begin
            r.status = held_code;
        end
        else if (dec_phase == PH_ENDED)
        begin
            r.status = ST_AFTER_END;
        end
        else if (bnd && region_count == 0)
        begin
            if (dec_phase == PH_TAG_FIRST)
            begin
                dec_phase = PH_ENDED;
                r.status = ST_AFTER_END;
            end
            else
            begin
                r.role = (dec_phase == PH_VALUE) ? ROLE_VALUE :
                         (dec_phase == PH_TAG_MORE) ? ROLE_TAG : ROLE_LENGTH;
                r.status = enter_error(ST_OVERRUN);
            end
        end
        else
        begin
            if (bnd)
                region_count = region_count - 1'b1;
            case (dec_phase)
                PH_TAG_FIRST:
                begin
                    r.role = ROLE_TAG;
                    tag_acc = {24'h0, b};
                    tag_count = 1;
                    len_acc = '0;
                    dec_phase = (b[4:0] == TAG_MULTI_MARK) ? PH_TAG_MORE : PH_LEN_FIRST;
                end
                PH_TAG_MORE:
                begin
                    r.role = ROLE_TAG;
                    if (tag_count >= MAX_TAG)
                    begin
                        r.status = enter_error(ST_TAG_LONG);
                    end
                    else
                    begin
                        tag_acc = {tag_acc[23:0], b};
                        tag_count++;
                        if (!b[7])
                            dec_phase = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    r.role = ROLE_LENGTH;
                    if (b[7])
                    begin
                        c = b[6:0];
                        if (c == 0)
                            r.status = enter_error(ST_INDEFINITE);
                        else if (c > MAX_LEN)
                            r.status = enter_error(ST_LEN_LONG);
                        else
                        begin
                            len_count = c[1:0];
                            len_acc = '0;
                            dec_phase = PH_LEN_MORE;
                        end
                    end
                    else
                    begin
                        len_acc = {16'h0, b};
                        hdr_end = 1'b1;
                    end
                end
                PH_LEN_MORE:
                begin
                    r.role = ROLE_LENGTH;
                    len_acc = {len_acc[15:0], b};
                    len_count = len_count - 1'b1;
                    if (len_count == 0)
                        hdr_end = 1'b1;
                end
                default:
                begin
                    r.role = ROLE_VALUE;
                    value_count = value_count - 1'b1;
                    if (value_count == 0)
                        obj_end = 1'b1;
                end
            endcase
            if (hdr_end)
            begin
                if (!bnd && tag_acc == 0)
                begin
                    r.region_end = 1'b1;
                    dec_phase = PH_ENDED;
                end
                else if (bnd && len_acc > region_count)
                begin
                    r.status = enter_error(ST_OVERRUN);
                end
                else
                begin
                    r.header_done = 1'b1;
                    value_count = len_acc;
                    if (value_count == 0)
                        obj_end = 1'b1;
                    else
                        dec_phase = PH_VALUE;
                end
            end
            if (obj_end)
            begin
                r.last_value = 1'b1;
                if (bnd && region_count == 0)
                begin
                    r.region_end = 1'b1;
                    dec_phase = PH_ENDED;
                end
                else
                begin
                    dec_phase = PH_TAG_FIRST;
                end
            end
        end
        r.tag = tag_acc;
        r.len = len_acc;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            restart <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                byte_reports_due.push_back(decode_byte(data_byte, restart));
            if (!in_valid || !in_stall)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_item = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_item.data;
                    restart <= next_item.restart;
                    if ($urandom_range(0, 31) == 0)
                        send_idle_mode = !send_idle_mode;
                    send_wait = send_idle_mode ? $urandom_range(0, 15) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (byte_reports_due.size() == 0)
                begin
                    $error("result item with none expected: passed_byte %0h", passed_byte);
                    mismatches++;
                end
                else
                begin
                    want = byte_reports_due.pop_front();
                    if (byte_role !== want.role)
                    begin
                        $error("byte_role expected %0d actual %0d", want.role, byte_role);
                        mismatches++;
                    end
                    if (passed_byte !== want.data)
                    begin
                        $error("passed_byte expected %0h actual %0h", want.data, passed_byte);
                        mismatches++;
                    end
                    if (header_done !== want.header_done)
                    begin
                        $error("header_done expected %0b actual %0b",
                               want.header_done, header_done);
                        mismatches++;
                    end
                    if (tag_value !== want.tag)
                    begin
                        $error("tag_value expected %0h actual %0h", want.tag, tag_value);
                        mismatches++;
                    end
                    if (length_value !== want.len)
                    begin
                        $error("length_value expected %0h actual %0h", want.len, length_value);
                        mismatches++;
                    end
                    if (last_value_byte !== want.last_value)
                    begin
                        $error("last_value_byte expected %0b actual %0b",
                               want.last_value, last_value_byte);
                        mismatches++;
                    end
                    if (region_end !== want.region_end)
                    begin
                        $error("region_end expected %0b actual %0b", want.region_end, region_end);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, status);
                        mismatches++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                begin
                    recv_wait = HOLD_CYCLES;
                end
                else
                begin
                    if ($urandom_range(0, 31) == 0)
                        recv_idle_mode = !recv_idle_mode;
                    recv_wait = recv_idle_mode ? $urandom_range(0, 15) : 0;
                end
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
            end
            out_stall <= (recv_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_tag_bytes();
        int r;
        r = $urandom_range(0, 15);
        return (r == 0) ? 5 : (r < 9) ? 1 : $urandom_range(2, 4);
    endfunction

    function automatic int pick_len_bytes();
        return ($urandom_range(0, 7) < 5) ? 0 : $urandom_range(1, 3);
    endfunction

    task automatic push_byte(logic [7:0] b, logic rs);
        stream_item_t it;
        it.data = b;
        it.restart = rs;
        pending_bytes.push_back(it);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_REGION_LENGTH)
            region_len_cfg = val;
        else
            unbounded_cfg = val[0];
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || byte_reports_due.size() != 0);
    endtask

    task automatic push_object(int n_tag, int long_k, int vlen, logic rs);
        logic [7:0] b;
        logic [23:0] lv;
        lv = 24'(vlen);
        if (n_tag == 1)
        begin
            b = 8'($urandom_range(1, 255));
            if (b[4:0] == TAG_MULTI_MARK)
                b[0] = 1'b0;
            push_byte(b, rs);
        end
        else
        begin
            b = rand_byte();
            b[4:0] = TAG_MULTI_MARK;
            push_byte(b, rs);
            for (int i = 2; i <= n_tag; i++)
            begin
                b = rand_byte();
                b[7] = (i != n_tag);
                push_byte(b, 1'b0);
            end
        end
        if (long_k == 0)
        begin
            push_byte(lv[7:0], 1'b0);
        end
        else
        begin
            push_byte(LONG_FORM | long_k[7:0], 1'b0);
            for (int i = long_k - 1; i >= 0; i--)
                push_byte(lv[8*i +: 8], 1'b0);
        end
        repeat (vlen) push_byte(rand_byte(), 1'b0);
    endtask

    task automatic push_region(logic bnd, int len_cfg);
        int rem;
        int n_tag;
        int k;
        int vlen;
        int hdr;
        logic first;
        first = 1'b1;
        if (bnd && len_cfg <= 64)
        begin
            rem = len_cfg;
            while (rem > 0)
            begin
                if (rem >= 12 && $urandom_range(0, 3) != 0)
                begin
                    n_tag = pick_tag_bytes();
                    k = pick_len_bytes();
                    hdr = n_tag + 1 + k;
                    vlen = $urandom_range(0, (rem - hdr > 8) ? 8 : rem - hdr);
                    if (rem - hdr - vlen == 1)
                        vlen++;
                    push_object(n_tag, k, vlen, first);
                    rem -= hdr + vlen;
                end
                else if (rem >= 2)
                begin
                    push_object(1, 0, rem - 2, first);
                    rem = 0;
                end
                else
                begin
                    push_byte(rand_byte(), first);
                    rem = 0;
                end
                first = 1'b0;
            end
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                push_object(pick_tag_bytes(), pick_len_bytes(), $urandom_range(0, 8), first);
                first = 1'b0;
            end
            if (!bnd)
            begin
                push_byte(8'h00, 1'b0);
                case ($urandom_range(0, 2))
                    0: push_byte(8'h00, 1'b0);
                    1: push_byte(8'($urandom_range(0, 127)), 1'b0);
                    default:
                    begin
                        push_byte(LONG_FORM | 8'd1, 1'b0);
                        push_byte(rand_byte(), 1'b0);
                    end
                endcase
                repeat ($urandom_range(0, 2)) push_byte(rand_byte(), 1'b0);
            end
        end
    endtask

    task automatic run_phase(logic unb, int len_cfg, int n_items);
        write_reg(CFG_REGION_UNBOUNDED, CFG_W'(unb));
        write_reg(CFG_REGION_LENGTH, CFG_W'(len_cfg));
        while (pending_bytes.size() < n_items)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    push_byte(rand_byte(), 1'b1);
                    repeat ($urandom_range(0, 11))
                        push_byte(rand_byte(), $urandom_range(0, 15) == 0);
                end
                1:
                begin
                    push_byte(rand_byte(), 1'b1);
                    push_byte(LONG_FORM | 8'($urandom_range(0, 7)), 1'b0);
                    repeat ($urandom_range(0, 4)) push_byte(rand_byte(), 1'b0);
                end
                default: push_region(!unb, len_cfg);
            endcase
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Bounded mode with no restart yet, then a restart with an empty region.
        write_reg(CFG_REGION_UNBOUNDED, CFG_W'(0));
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        wait_idle();

        // Tag too long, indefinite length, length too long and a length overrun.
        write_reg(CFG_REGION_LENGTH, 24'hFFFFFF);
        push_byte(8'h1F, 1'b1);
        push_byte(8'h81, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h83, 1'b0);
        push_byte(8'h84, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(LONG_FORM, 1'b0);
        push_byte(8'h02, 1'b1);
        push_byte(8'h84, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h83, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        wait_idle();

        // An empty object that exactly uses up a bounded region, then a byte after its end.
        write_reg(CFG_REGION_LENGTH, CFG_W'(4));
        push_byte(8'h1F, 1'b1);
        push_byte(8'h81, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h33, 1'b0);
        wait_idle();

        // Unbounded mode: an empty object, then tag zero ends the region.
        write_reg(CFG_REGION_UNBOUNDED, CFG_W'(1));
        push_byte(8'h05, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h07, 1'b0);
        wait_idle();

        run_phase(1'b1, 0, 180);
        run_phase(1'b0, 24, 180);
        run_phase(1'b0, 2, 80);
        run_phase(1'b0, 64, 200);
        run_phase(1'b1, 24'hFFFFFF, 180);
        run_phase(1'b0, 24'hFFFFFF, 140);
        run_phase(1'b0, $urandom_range(3, 63), 160);

        repeat (16) @(posedge clk);
        if (mismatches == 0 && byte_reports_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
